>>> hdl/cgq_pkg.sv
// ----------------------------------------------------------------------------
// cgq_pkg
// Shared constants and widths for the crop / scale / gamma / quantise block.
// ----------------------------------------------------------------------------
package cgq_pkg;

  localparam int SRC_WIDTH  = 320;
  localparam int SRC_HEIGHT = 240;
  localparam int DST_WIDTH  = 96;
  localparam int DST_HEIGHT = 96;

  // exact rational stepping: quotient and remainder per output pixel / line
  localparam int COL_STEP = SRC_HEIGHT / DST_WIDTH;
  localparam int COL_REM  = SRC_HEIGHT % DST_WIDTH;
  localparam int LINE_STEP = SRC_HEIGHT / DST_HEIGHT;
  localparam int LINE_REM  = SRC_HEIGHT % DST_HEIGHT;

  localparam int CROP_LIM = (SRC_WIDTH > SRC_HEIGHT) ? SRC_WIDTH - SRC_HEIGHT : 0;

  localparam int SCOL_W  = $clog2(SRC_WIDTH + COL_STEP + 2);
  localparam int SLINE_W = $clog2(SRC_HEIGHT + LINE_STEP + 2);
  localparam int DCOL_W  = $clog2(DST_WIDTH + 1);
  localparam int DLINE_W = $clog2(DST_HEIGHT + 1);
  localparam int CREM_W  = $clog2(DST_WIDTH + COL_REM + 1);
  localparam int LREM_W  = $clog2(DST_HEIGHT + LINE_REM + 1);

  localparam int PIX_W   = 8;
  localparam int MULT_W  = 24;
  localparam int ZP_W    = 8;
  localparam int CROP_W  = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam int FRAC_W  = 16;
  localparam int PROD_W  = PIX_W + MULT_W;
  localparam int SUM_W   = PROD_W + 2;

  localparam logic [MULT_W-1:0] MULT_RESET = MULT_W'(65536);
  localparam logic [CROP_W-1:0] CROP_RESET = CROP_W'(40);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUANT_MULT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUANT_OFFSET = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_START   = 2'd3;

  // request codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

endpackage

>>> hdl/cgq_if.sv
// ----------------------------------------------------------------------------
// cgq_if
// Valid/ready channels: source pixel / table load beats in, result beats out.
// ----------------------------------------------------------------------------
interface cgq_in_if import cgq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [PIX_W-1:0]  table_index;
  logic [PIX_W-1:0]  table_value;
  logic              start_of_frame;
  logic [PIX_W-1:0]  red;
  logic [PIX_W-1:0]  green;
  logic [PIX_W-1:0]  blue;

  modport source (output valid, req_type, table_index, table_value, start_of_frame,
                  red, green, blue, input ready);
  modport sink   (input valid, req_type, table_index, table_value, start_of_frame,
                  red, green, blue, output ready);
endinterface

interface cgq_out_if import cgq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PIX_W-1:0]  out_red;
  logic [PIX_W-1:0]  out_green;
  logic [PIX_W-1:0]  out_blue;
  logic              end_of_frame;

  modport source (output valid, out_red, out_green, out_blue, end_of_frame, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, end_of_frame, output ready);
endinterface

>>> hdl/crop_scale_gamma_quantize.sv
// ----------------------------------------------------------------------------
// crop_scale_gamma_quantize
// Square crop (centred at reset), nearest-neighbour downscale, gamma table, optional int8 quantise.
// ----------------------------------------------------------------------------
// One beat per clock in, at most one out: a pixel or table load is taken every
// cycle while the output side keeps up, and a kept pixel's result beat passes
// the gamma memory read, the quantiser multiply and the truncate/saturate into
// the output register. The rate is set by the raster counters, which update
// once per beat, and by the gamma memories, which serve all three colour
// channels in the same cycle. The gamma table is not cleared by reset; load
// every entry that a frame will use before sending its pixels. Table loads
// never produce a result. Configuration is to be written by the user only
// while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module crop_scale_gamma_quantize
  import cgq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  cgq_in_if.sink                src,
  cgq_out_if.source             res
);

  // configuration registers
  logic                output_mode;
  logic [MULT_W-1:0]   quant_multiplier;
  logic [ZP_W-1:0]     quant_offset;
  logic [CROP_W-1:0]   crop_start_col;

  // raster state
  logic [SCOL_W-1:0]   src_col, src_col_next;
  logic [SLINE_W-1:0]  src_line, src_line_next;
  logic [DCOL_W-1:0]   dst_col, dst_col_next;
  logic [DLINE_W-1:0]  dst_line, dst_line_next;
  logic [SCOL_W-1:0]   col_target, col_target_next;
  logic [SLINE_W-1:0]  line_target, line_target_next;
  logic [CREM_W-1:0]   col_remainder, col_remainder_next;
  logic [LREM_W-1:0]   line_remainder, line_remainder_next;

  logic [SCOL_W-1:0]   crop_eff;
  logic                keep, keep_eof;

  // gamma memories: copy a serves red and green, copy b serves blue
  logic [PIX_W-1:0]    gamma_a [256];
  logic [PIX_W-1:0]    gamma_b [256];

  // pipeline
  logic                v1, v2;
  logic                eof1, eof2;
  logic [PIX_W-1:0]    g1 [3];
  logic [PIX_W-1:0]    g2 [3];
  logic [PROD_W-1:0]   prod2 [3];
  logic                adv1, adv2, adv3;
  logic                take, take_pix, take_load;
  logic [PIX_W-1:0]    res_byte [3];

  // handshake: each stage moves when the one after it is free or moving
  assign adv3 = res.ready || !res.valid;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign src.ready = adv1;
  assign take      = src.valid && adv1;
  assign take_pix  = take && (src.req_type == REQ_PIXEL);
  assign take_load = take && (src.req_type == REQ_LOAD);

  // crop start clamped so the square stays inside the row
  assign crop_eff = (SCOL_W'(crop_start_col) > SCOL_W'(CROP_LIM)) ?
                    SCOL_W'(CROP_LIM) : SCOL_W'(crop_start_col);

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (rst) begin
      output_mode      <= 1'b0;
      quant_multiplier <= MULT_RESET;
      quant_offset     <= '0;
      crop_start_col   <= CROP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OUTPUT_MODE:  output_mode      <= cfg_data[0];
        REG_QUANT_MULT:   quant_multiplier <= cfg_data[MULT_W-1:0];
        REG_QUANT_OFFSET: quant_offset     <= cfg_data[ZP_W-1:0];
        REG_CROP_START:   crop_start_col   <= cfg_data[CROP_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- raster counters and decimation decision ----
  always_comb begin
    logic               row_kept;
    logic [SCOL_W-1:0]  sc;
    logic [SLINE_W-1:0] sl;
    logic [CREM_W-1:0]  cr_sum;
    logic [LREM_W-1:0]  lr_sum;

    src_col_next        = src_col;
    src_line_next       = src_line;
    dst_col_next        = dst_col;
    dst_line_next       = dst_line;
    col_target_next     = col_target;
    line_target_next    = line_target;
    col_remainder_next  = col_remainder;
    line_remainder_next = line_remainder;
    cr_sum              = '0;
    lr_sum              = '0;

    // start of frame restarts everything, pixel taken as column 0 row 0
    if (src.start_of_frame) begin
      src_col_next        = '0;
      src_line_next       = '0;
      dst_line_next       = '0;
      line_target_next    = '0;
      line_remainder_next = '0;
      dst_col_next        = '0;
      col_target_next     = crop_eff;
      col_remainder_next  = '0;
    end

    sc = src_col_next;
    sl = src_line_next;
    row_kept = (sl == line_target_next) && (dst_line_next < DLINE_W'(DST_HEIGHT));
    keep     = row_kept && (sc == col_target_next) && (dst_col_next < DCOL_W'(DST_WIDTH));
    keep_eof = (dst_col_next == DCOL_W'(DST_WIDTH - 1)) &&
               (dst_line_next == DLINE_W'(DST_HEIGHT - 1));

    if (keep) begin
      dst_col_next    = dst_col_next + DCOL_W'(1);
      col_target_next = col_target_next + SCOL_W'(COL_STEP);
      cr_sum          = col_remainder_next + CREM_W'(COL_REM);
      if (cr_sum >= CREM_W'(DST_WIDTH)) begin
        cr_sum          = cr_sum - CREM_W'(DST_WIDTH);
        col_target_next = col_target_next + SCOL_W'(1);
      end
      col_remainder_next = cr_sum;
    end

    if (sc == SCOL_W'(SRC_WIDTH - 1)) begin
      src_col_next = '0;
      if (row_kept) begin
        dst_line_next    = dst_line_next + DLINE_W'(1);
        line_target_next = line_target_next + SLINE_W'(LINE_STEP);
        lr_sum           = line_remainder_next + LREM_W'(LINE_REM);
        if (lr_sum >= LREM_W'(DST_HEIGHT)) begin
          lr_sum           = lr_sum - LREM_W'(DST_HEIGHT);
          line_target_next = line_target_next + SLINE_W'(1);
        end
        line_remainder_next = lr_sum;
      end
      dst_col_next       = '0;
      col_target_next    = crop_eff;
      col_remainder_next = '0;
      if (sl == SLINE_W'(SRC_HEIGHT - 1)) begin
        // last pixel of the frame: wrap, so the next frame needs no start-of-frame mark
        src_line_next       = '0;
        dst_line_next       = '0;
        line_target_next    = '0;
        line_remainder_next = '0;
      end else begin
        src_line_next = sl + SLINE_W'(1);
      end
    end else begin
      src_col_next = sc + SCOL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_col        <= '0;
      src_line       <= '0;
      dst_col        <= '0;
      dst_line       <= '0;
      col_target     <= SCOL_W'(CROP_RESET > CROP_W'(CROP_LIM) ? CROP_W'(CROP_LIM) : CROP_RESET);
      line_target    <= '0;
      col_remainder  <= '0;
      line_remainder <= '0;
    end else if (take_pix) begin
      src_col        <= src_col_next;
      src_line       <= src_line_next;
      dst_col        <= dst_col_next;
      dst_line       <= dst_line_next;
      col_target     <= col_target_next;
      line_target    <= line_target_next;
      col_remainder  <= col_remainder_next;
      line_remainder <= line_remainder_next;
    end
  end

  // ---- gamma memories: write on a load beat, read on a pixel beat ----
  always_ff @(posedge clk) begin
    if (take_load) begin
      gamma_a[src.table_index] <= src.table_value;
      gamma_b[src.table_index] <= src.table_value;
    end
    if (take_pix) begin
      g1[0] <= gamma_a[src.red];
      g1[1] <= gamma_a[src.green];
      g1[2] <= gamma_b[src.blue];
      eof1  <= keep_eof;
    end
  end

  // ---- pipeline valids ----
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      if (adv1) v1 <= take_pix && keep;
      if (adv2) v2 <= v1;
      if (adv3) res.valid <= v2;
    end
  end

  // stage 2: multiply by the Q8.16 factor
  always_ff @(posedge clk) begin
    if (adv2 && v1) begin
      for (int i = 0; i < 3; i++) begin
        g2[i]    <= g1[i];
        prod2[i] <= PROD_W'(g1[i]) * PROD_W'(quant_multiplier);
      end
      eof2 <= eof1;
    end
  end

  // stage 3: add zero point, truncate toward zero, saturate to int8
  function automatic logic [PIX_W-1:0] quant_byte(input logic [PROD_W-1:0] p,
                                                  input logic [ZP_W-1:0] zp);
    logic signed [SUM_W-1:0]        t;
    logic signed [SUM_W-1:0]        tb;
    logic signed [SUM_W-FRAC_W-1:0] q;
    t  = $signed({2'b00, p}) +
         $signed({{(SUM_W-ZP_W-FRAC_W){zp[ZP_W-1]}}, zp, {FRAC_W{1'b0}}});
    tb = t[SUM_W-1] ? t + SUM_W'((1 << FRAC_W) - 1) : t;
    q  = tb[SUM_W-1:FRAC_W];
    if (q > 127)       quant_byte = 8'h7F;
    else if (q < -128) quant_byte = 8'h80;
    else               quant_byte = q[PIX_W-1:0];
  endfunction

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      res_byte[i] = output_mode ? quant_byte(prod2[i], quant_offset) : g2[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && v2) begin
      res.out_red      <= res_byte[0];
      res.out_green    <= res_byte[1];
      res.out_blue     <= res_byte[2];
      res.end_of_frame <= eof2;
    end
  end

endmodule
